// ----- hdl/bdcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcr_pkg: shared types and constants of the block dc offset remover
// widths of sample, sum, ring and divider paths, controller states
// ----------------------------------------------------------------------------
`default_nettype none

package bdcr_pkg;

   // sample path
   localparam int SAMPLE_W   = 32;
   localparam int HALF_W     = SAMPLE_W - 1;
   localparam int SCALED_W   = HALF_W - 8;
   localparam int OUT_W      = 16;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int OUT_SHIFT  = 15;

   // block buffer
   localparam int BLK_DEPTH  = 64;
   localparam int BLK_IDX_W  = $clog2(BLK_DEPTH);
   localparam int BLK_CNT_W  = BLK_IDX_W + 1;
   localparam int SUM_W      = 29;

   // mean history ring
   localparam int HIST_DEPTH  = 128;
   localparam int HIST_IDX_W  = $clog2(HIST_DEPTH);
   localparam int HIST_FILL_W = HIST_IDX_W + 1;
   localparam int MEAN_W      = 23;
   localparam int TOTAL_W     = 30;

   // shared divider
   localparam int DIV_W     = TOTAL_W;
   localparam int DVS_W     = 8;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_MEAN_DIV,
      ST_RING_UPD,
      ST_AVG_DIV,
      ST_DRAIN_RD,
      ST_DRAIN_WR
   } state_type;

   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic [DVS_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- hdl/bdcr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcr_if: valid/ready channels of the block dc offset remover
// sample channel and corrected audio channel
// ----------------------------------------------------------------------------
`default_nettype none

interface bdcr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [bdcr_pkg::SAMPLE_W-1:0]   mic_sample;
   logic                                   block_end;

   modport source (output valid, output mic_sample, output block_end, input ready);
   modport sink   (input valid, input mic_sample, input block_end, output ready);
endinterface

interface bdcr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [bdcr_pkg::OUT_W-1:0]      audio_out;
   logic                                   last_out;

   modport source (output valid, output audio_out, output last_out, input ready);
   modport sink   (input valid, input audio_out, input last_out, output ready);
endinterface

`default_nettype wire

// ----- hdl/bdcr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcr_div: signed by unsigned divider, one quotient bit per cycle
// truncates toward zero; done pulses one cycle, quotient holds until next start
// ----------------------------------------------------------------------------
`default_nettype none

module bdcr_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bdcr_pkg::div_req_type div_req,
   output      bdcr_pkg::div_rsp_type div_rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              neg_ff, neg_in;
   logic [bdcr_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [bdcr_pkg::DIV_W-1:0]        quo_ff, quo_in;
   logic [bdcr_pkg::DVS_W-1:0]        rem_ff, rem_in;
   logic [bdcr_pkg::DVS_W-1:0]        dvs_ff, dvs_in;
   logic [bdcr_pkg::DVS_W:0]          shifted;
   logic [bdcr_pkg::DVS_W:0]          diff;
   logic                              ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[bdcr_pkg::DIV_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[bdcr_pkg::DIV_W-1];
         quo_in  = neg_in ? (~div_req.dividend + 1'b1) : div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         quo_in = {quo_ff[bdcr_pkg::DIV_W-2:0], ge};
         rem_in = ge ? diff[bdcr_pkg::DVS_W-1:0] : shifted[bdcr_pkg::DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bdcr_pkg::DIV_CNT_W'(bdcr_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

`default_nettype wire

// ----- hdl/block_dc_offset_remover_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_dc_offset_remover_top: block dc offset remover
// buffers halved samples of a block, keeps a ring of block means and
// subtracts their average from every sample of the block at block end
// ----------------------------------------------------------------------------
//
//  channel   dir   beat                          handshake
//  req_bus   in    mic_sample[31:0], block_end   valid/ready
//  rsp_bus   out   audio_out[15:0], last_out     valid/ready
//
//  sample beats are taken back to back while collecting; a block closes on
//  block_end or on its 64th sample, then two passes of the shared divider
//  (block mean, then ring average) around one ring-update state run
//  results then leave through a read state and a write state each, as the
//  read of the sample buffer is registered; no sample is taken from block
//  end until the last result is loaded
//  synchronous active-high reset clears control state, memories are not
//  cleared; a stalled rsp_bus holds the drain, the output register decouples
// ----------------------------------------------------------------------------
`default_nettype none

module block_dc_offset_remover_top (
   input  wire logic clock,
   input  wire logic reset,
   bdcr_req_if.sink   req_bus,
   bdcr_rsp_if.source rsp_bus
);

   // controller
   bdcr_pkg::state_type                      state_ff, state_in;

   // block accumulation
   logic signed [bdcr_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [bdcr_pkg::BLK_CNT_W-1:0]           count_ff, count_in;

   // ring bookkeeping
   logic [bdcr_pkg::HIST_IDX_W-1:0]          hist_idx_ff, hist_idx_in;
   logic [bdcr_pkg::HIST_FILL_W-1:0]         fill_ff, fill_in;
   logic signed [bdcr_pkg::TOTAL_W-1:0]      total_ff, total_in;
   logic signed [bdcr_pkg::MEAN_W-1:0]       mean_ff, mean_in;
   logic signed [bdcr_pkg::MEAN_W-1:0]       avg_ff, avg_in;

   // drain
   logic [bdcr_pkg::BLK_IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic signed [bdcr_pkg::OUT_W-1:0]        rsp_audio_ff, rsp_audio_in;
   logic                                     rsp_last_ff, rsp_last_in;

   // sample buffer memory
   logic signed [bdcr_pkg::HALF_W-1:0]       buf_mem [bdcr_pkg::BLK_DEPTH];
   logic                                     buf_we;
   logic signed [bdcr_pkg::HALF_W-1:0]       buf_wd;
   logic signed [bdcr_pkg::HALF_W-1:0]       buf_rd_ff;

   // mean history memory
   logic signed [bdcr_pkg::MEAN_W-1:0]       hist_mem [bdcr_pkg::HIST_DEPTH];
   logic                                     hist_we;
   logic signed [bdcr_pkg::MEAN_W-1:0]       hist_rd_ff;

   // divider
   bdcr_pkg::div_req_type                    div_req;
   bdcr_pkg::div_rsp_type                    div_rsp;

   // datapath helpers
   logic signed [bdcr_pkg::HALF_W-1:0]       half;
   logic signed [bdcr_pkg::SUM_W-1:0]        sum_next;
   logic [bdcr_pkg::BLK_CNT_W-1:0]           count_next;
   logic                                     hist_full;
   logic signed [bdcr_pkg::MEAN_W-1:0]       old_mean;
   logic signed [bdcr_pkg::DIFF_W-1:0]       diff;
   logic signed [bdcr_pkg::DIFF_W-bdcr_pkg::OUT_SHIFT-1:0] shifted;
   logic signed [bdcr_pkg::OUT_W-1:0]        sat;
   logic                                     is_last;
   logic                                     out_free;

   bdcr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      // halve, then shift down by 8 bits for the block sum
      half       = req_bus.mic_sample[bdcr_pkg::SAMPLE_W-1:1];
      sum_next   = sum_ff + bdcr_pkg::SUM_W'(signed'(half[bdcr_pkg::HALF_W-1:8]));
      count_next = count_ff + 1'b1;

      // oldest ring entry leaves the total once the ring is full
      hist_full  = (fill_ff == bdcr_pkg::HIST_FILL_W'(bdcr_pkg::HIST_DEPTH));
      old_mean   = hist_full ? hist_rd_ff : '0;

      // offset subtraction at 33 bits, shift and saturate
      diff    = bdcr_pkg::DIFF_W'(buf_rd_ff)
              - bdcr_pkg::DIFF_W'(signed'({avg_ff, 8'b0}));
      shifted = diff[bdcr_pkg::DIFF_W-1:bdcr_pkg::OUT_SHIFT];
      if (shifted > (bdcr_pkg::DIFF_W-bdcr_pkg::OUT_SHIFT)'(bdcr_pkg::OUT_MAX)) begin
         sat = bdcr_pkg::OUT_MAX;
      end else if (shifted < (bdcr_pkg::DIFF_W-bdcr_pkg::OUT_SHIFT)'(bdcr_pkg::OUT_MIN)) begin
         sat = bdcr_pkg::OUT_MIN;
      end else begin
         sat = shifted[bdcr_pkg::OUT_W-1:0];
      end
      is_last  = ({1'b0, rd_idx_ff} + 1'b1) == count_ff;
      out_free = !rsp_valid_ff || rsp_bus.ready;
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      hist_idx_in  = hist_idx_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      mean_in      = mean_ff;
      avg_in       = avg_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_audio_in = rsp_audio_ff;
      rsp_last_in  = rsp_last_ff;
      buf_we       = 1'b0;
      buf_wd       = half;
      hist_we      = 1'b0;
      div_req      = '{start: 1'b0, dividend: '0, divisor: '0};
      req_bus.ready = 1'b0;

      unique case (state_ff)
         bdcr_pkg::ST_COLLECT: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               buf_we   = 1'b1;
               sum_in   = sum_next;
               count_in = count_next;
               // block closes on the mark or on a full buffer
               if (req_bus.block_end ||
                   count_next == bdcr_pkg::BLK_CNT_W'(bdcr_pkg::BLK_DEPTH)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = bdcr_pkg::DIV_W'(sum_next);
                  div_req.divisor  = bdcr_pkg::DVS_W'(count_next);
                  state_in         = bdcr_pkg::ST_MEAN_DIV;
               end
            end
         end
         bdcr_pkg::ST_MEAN_DIV: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient[bdcr_pkg::MEAN_W-1:0];
               state_in = bdcr_pkg::ST_RING_UPD;
            end
         end
         bdcr_pkg::ST_RING_UPD: begin
            hist_we  = 1'b1;
            total_in = total_ff - bdcr_pkg::TOTAL_W'(old_mean)
                     + bdcr_pkg::TOTAL_W'(mean_ff);
            if (!hist_full) begin
               fill_in = fill_ff + 1'b1;
            end
            if (hist_idx_ff == bdcr_pkg::HIST_IDX_W'(bdcr_pkg::HIST_DEPTH - 1)) begin
               hist_idx_in = '0;
            end else begin
               hist_idx_in = hist_idx_ff + 1'b1;
            end
            div_req.start    = 1'b1;
            div_req.dividend = total_in;
            div_req.divisor  = fill_in;
            state_in         = bdcr_pkg::ST_AVG_DIV;
         end
         bdcr_pkg::ST_AVG_DIV: begin
            if (div_rsp.done) begin
               avg_in    = div_rsp.quotient[bdcr_pkg::MEAN_W-1:0];
               rd_idx_in = '0;
               state_in  = bdcr_pkg::ST_DRAIN_RD;
            end
         end
         bdcr_pkg::ST_DRAIN_RD: begin
            // buffer read of rd_idx lands next cycle
            state_in = bdcr_pkg::ST_DRAIN_WR;
         end
         bdcr_pkg::ST_DRAIN_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_audio_in = sat;
               rsp_last_in  = is_last;
               if (is_last) begin
                  sum_in   = '0;
                  count_in = '0;
                  state_in = bdcr_pkg::ST_COLLECT;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
                  state_in  = bdcr_pkg::ST_DRAIN_RD;
               end
            end
         end
         default: begin
            state_in = bdcr_pkg::ST_COLLECT;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdcr_pkg::ST_COLLECT;
         sum_ff       <= '0;
         count_ff     <= '0;
         hist_idx_ff  <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         hist_idx_ff  <= hist_idx_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff      <= mean_in;
      avg_ff       <= avg_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_audio_ff <= rsp_audio_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // sample buffer: write at fill position, read at drain position
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[count_ff[bdcr_pkg::BLK_IDX_W-1:0]] <= buf_wd;
      end
      buf_rd_ff <= buf_mem[rd_idx_ff];
   end

   // mean ring: read and write share the current slot index
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_idx_ff] <= mean_ff;
      end
      hist_rd_ff <= hist_mem[hist_idx_ff];
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.audio_out = rsp_audio_ff;
   assign rsp_bus.last_out  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the block dc offset remover
// sends blocks of microphone samples with random gaps and back-pressure,
// predicts the corrected audio of each block from the accepted beats and
// compares every result beat, field by field, in order
// ----------------------------------------------------------------------------

module tb_top;

   // a block end runs two divider passes and a ring update before the first
   // result, so a run of WATCHDOG_LIMIT silent cycles can only mean a hang
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int DRAIN_TAIL       = 200;
   localparam int MAX_REPORTS      = 10;
   // closed blocks needed to fill the mean ring and overwrite a few entries
   localparam int RING_WRAP_BLOCKS = bdcr_pkg::HIST_DEPTH + 4;

   localparam logic signed [bdcr_pkg::SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;
   localparam logic signed [bdcr_pkg::SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [bdcr_pkg::OUT_W-1:0] audio;
      logic                              last;
   } audio_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdcr_req_if req_bus ();
   bdcr_rsp_if rsp_bus ();

   block_dc_offset_remover_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // ---------------------------------------------------------------------
   // predictor state: halved samples of the open block, its scaled sum and
   // the ring of block means with its running total
   // ---------------------------------------------------------------------
   logic signed [bdcr_pkg::HALF_W-1:0]  half_buf[$];
   logic signed [bdcr_pkg::SUM_W-1:0]   blk_sum = '0;
   logic signed [bdcr_pkg::MEAN_W-1:0]  mean_ring[bdcr_pkg::HIST_DEPTH];
   int                                  ring_wr = 0;
   int                                  ring_fill = 0;
   logic signed [bdcr_pkg::TOTAL_W-1:0] ring_total = '0;
   int                                  blocks_closed = 0;

   // corrected audio still owed by the block, oldest first
   audio_beat_type expected_audio[$];

   int          fail_count = 0;
   int          idle_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor: takes one accepted sample beat; on block close it pushes
   // one expected audio beat per buffered sample
   // ---------------------------------------------------------------------
   task automatic absorb_sample(input logic signed [bdcr_pkg::SAMPLE_W-1:0] sample,
                                input logic mark);
      longint         half;
      longint         mean;
      longint         offset;
      longint         diff;
      longint         y;
      int             n;
      int             k;
      audio_beat_type beat;

      half = longint'(sample) >>> 1;
      half_buf.push_back(bdcr_pkg::HALF_W'(half));
      blk_sum = bdcr_pkg::SUM_W'(longint'(blk_sum) + (half >>> 8));
      n = half_buf.size();

      // block stays open until marked or full
      if (!mark && n < bdcr_pkg::BLK_DEPTH)
         return;

      // block mean, truncated toward zero, goes into the ring
      mean = longint'(blk_sum) / longint'(n);
      if (ring_fill >= bdcr_pkg::HIST_DEPTH)
         ring_total = bdcr_pkg::TOTAL_W'(longint'(ring_total)
                                         - longint'(mean_ring[ring_wr]));
      else
         ring_fill++;
      mean_ring[ring_wr] = bdcr_pkg::MEAN_W'(mean);
      ring_total = bdcr_pkg::TOTAL_W'(longint'(ring_total) + mean);
      ring_wr = (ring_wr + 1) % bdcr_pkg::HIST_DEPTH;

      // dc offset is the ring average scaled back up by 256
      offset = (longint'(ring_total) / longint'(ring_fill)) * 256;

      for (k = 0; k < n; k++) begin
         diff = longint'(half_buf[k]) - offset;
         y = diff >>> bdcr_pkg::OUT_SHIFT;
         if (y > longint'(bdcr_pkg::OUT_MAX))
            y = longint'(bdcr_pkg::OUT_MAX);
         else if (y < longint'(bdcr_pkg::OUT_MIN))
            y = longint'(bdcr_pkg::OUT_MIN);
         beat.audio = bdcr_pkg::OUT_W'(y);
         beat.last  = (k == n - 1);
         expected_audio.push_back(beat);
      end

      half_buf.delete();
      blk_sum = '0;
      blocks_closed++;
   endtask

   task automatic flag_error(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_result(input logic signed [bdcr_pkg::OUT_W-1:0] audio,
                               input logic last);
      audio_beat_type want;

      if (expected_audio.size() == 0) begin
         flag_error($sformatf("unexpected beat: audio_out=%0d last_out=%b", audio, last));
         return;
      end
      want = expected_audio.pop_front();
      if (audio !== want.audio)
         flag_error($sformatf("audio_out: expected %0d, got %0d", want.audio, audio));
      if (last !== want.last)
         flag_error($sformatf("last_out: expected %b, got %b", want.last, last));
   endtask

   // ---------------------------------------------------------------------
   // monitor: samples both channels at the edge, feeds the predictor,
   // checks results and runs the watchdog on silent cycles
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            check_result(rsp_bus.audio_out, rsp_bus.last_out);
         if (req_bus.valid && req_bus.ready)
            absorb_sample(req_bus.mic_sample, req_bus.block_end);

         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;

         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // receiver back-pressure, redrawn every cycle, low during reset
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // ---------------------------------------------------------------------
   // sender: optional idle cycles, then holds the beat until taken; valid
   // is left high so back-to-back beats never drop it
   // ---------------------------------------------------------------------
   task automatic send_sample(input logic signed [bdcr_pkg::SAMPLE_W-1:0] sample,
                              input logic mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mic_sample <= sample;
      req_bus.block_end  <= mark;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
   endtask

   // sender goes quiet until every owed result beat has been taken
   task automatic pause_until_drained();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (expected_audio.size() != 0);
   endtask

   // microphone-like word: a dc level plus noise or a fully random word,
   // each as often as the other, else rail values and minus one
   function automatic logic signed [bdcr_pkg::SAMPLE_W-1:0] mic_word(
      input logic signed [bdcr_pkg::SAMPLE_W-1:0] bias);
      int unsigned pick;

      pick = $urandom_range(99);
      if (pick < 8)
         return S_MAX;
      if (pick < 16)
         return S_MIN;
      if (pick < 20)
         return -32'sd1;
      if (pick < 60)
         return bias + $urandom_range(65535) - 32768;
      return $urandom;
   endfunction

   task automatic send_block(input int n, input logic mark_last);
      logic signed [bdcr_pkg::SAMPLE_W-1:0] bias;
      int                                   k;

      bias = $urandom;
      for (k = 0; k < n; k++)
         send_sample(mic_word(bias), mark_last && (k == n - 1));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // rail samples, zero, tiny values around zero and odd values whose
   // halving and scaling round toward minus infinity
   task automatic test_extremes();
      set_idling(29, 86);
      send_sample(S_MAX, 1'b1);
      send_sample(S_MIN, 1'b1);
      send_sample(32'sd0, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd1, 1'b1);
      send_sample(32'sh0000_01ff, 1'b0);
      send_sample(32'shffff_fe01, 1'b1);
   endtask

   // drag the offset far negative then far positive so the output clips
   // at both ends
   task automatic test_saturation();
      repeat (4) send_sample(S_MIN, 1'b1);
      send_sample(S_MAX, 1'b0);
      send_sample(S_MAX, 1'b1);
      repeat (6) send_sample(S_MAX, 1'b1);
      send_sample(S_MIN, 1'b1);
   endtask

   // unmarked block that must close on its own at full depth
   task automatic test_full_block();
      set_idling(86, 29);
      send_block(bdcr_pkg::BLK_DEPTH, 1'b0);
   endtask

   // one-sample blocks until the mean ring is full and its oldest entries
   // are overwritten
   task automatic test_ring_wrap();
      set_idling(0, 0);
      while (blocks_closed < RING_WRAP_BLOCKS)
         send_block(1, 1'b1);
   endtask

   task automatic finish_run();
      pause_until_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fail_count == 0 && expected_audio.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   endtask

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.mic_sample <= '0;
      req_bus.block_end  <= 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_saturation();
      // hold off until the directed blocks are fully out
      pause_until_drained();
      test_full_block();
      test_ring_wrap();
      finish_run();
   end

endmodule
